@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/ssru_pkg.sv @@
package ssru_pkg;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned LOOP_DIMS  = 4;
  localparam int unsigned ADDR_WIDTH = 32;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned DIM_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_RSTART = 3'd1,
    MODE_WSTART = 3'd2,
    MODE_POP    = 3'd3,
    MODE_PUSH   = 3'd4,
    MODE_LRET   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_POP_ERR = 2'd1,
    ST_PUSH_ERR = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BOUND0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE0 = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] start_address;
    logic [1:0]  top_dimension;
    logic [7:0]  repeat_times;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    logic [0:0]  mem_request;
    logic [0:0]  mem_is_write;
    logic [31:0] mem_address;
    logic [63:0] mem_write_data;
    logic [63:0] pop_value;
    logic [1:0]  status;
    logic [0:0]  stream_active;
  } result_t;
endpackage

@@ rtl/core/ssru_front.sv @@
module ssru_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssru_pkg::item_t  in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output ssru_pkg::item_t  q_item
);
  localparam int unsigned QD = ssru_pkg::QUEUE_DEPTH;

  ssru_pkg::item_t buf_r [QD];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = (cnt_r != 2'(QD));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_item;
  end
endmodule

@@ rtl/core/ssru_back.sv @@
module ssru_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata,
  input  logic             q_valid,
  output logic             q_ready,
  input  ssru_pkg::item_t  q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output ssru_pkg::result_t res,
  output logic             running
);
  localparam int unsigned D  = ssru_pkg::FIFO_DEPTH;
  localparam int unsigned PW = ssru_pkg::PTR_W;
  localparam int unsigned CW = ssru_pkg::CNT_W;
  localparam int unsigned AW = ssru_pkg::ADDR_WIDTH;
  localparam int unsigned ND = ssru_pkg::LOOP_DIMS;

  logic [31:0] bound_r [ND];
  logic [31:0] stride_r [ND];
  logic [63:0] rfifo_r [D];
  logic [63:0] wfifo_r [D];

  logic [PW-1:0] rhead_r, rtail_r, whead_r, wtail_r;
  logic [PW-1:0] rhead_nxt, rtail_nxt, whead_nxt, wtail_nxt;
  logic [CW-1:0] rcount_r, rres_r, wcount_r;
  logic [CW-1:0] rcount_nxt, rres_nxt, wcount_nxt;
  logic [7:0]    rep_cnt_r, rep_lim_r, rep_cnt_nxt, rep_lim_nxt;
  logic [31:0]   idx_r [ND];
  logic [31:0]   idx_nxt [ND];
  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0]    udim_r, udim_nxt;
  logic          dirw_r, dirw_nxt, run_r, run_nxt;
  logic          out_v_r;
  ssru_pkg::result_t out_r, res_nxt;
  logic          go, rfifo_we, wfifo_we;

  assign q_ready   = !out_v_r || res_ready;
  assign go        = q_valid && q_ready;
  assign res_valid = out_v_r;
  assign res       = out_r;
  assign running   = run_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (32'(p) + 32'd1 >= D) ? '0 : PW'(32'(p) + 32'd1);
  endfunction

  always_comb begin
    logic adv, done, wrapped;
    logic [1:0] dim;
    rhead_nxt = rhead_r; rtail_nxt = rtail_r;
    whead_nxt = whead_r; wtail_nxt = wtail_r;
    rcount_nxt = rcount_r; rres_nxt = rres_r; wcount_nxt = wcount_r;
    rep_cnt_nxt = rep_cnt_r; rep_lim_nxt = rep_lim_r;
    idx_nxt = idx_r; addr_nxt = addr_r; udim_nxt = udim_r;
    dirw_nxt = dirw_r; run_nxt = run_r;
    res_nxt = '0;
    rfifo_we = 1'b0; wfifo_we = 1'b0;
    adv = 1'b0; done = 1'b0; wrapped = 1'b0;
    dim = (q_item.top_dimension > 2'(ND - 1)) ? 2'(ND - 1) : q_item.top_dimension;
    unique case (q_item.mode)
      ssru_pkg::MODE_TICK: begin
        if (dirw_r) begin
          if (wcount_r != '0) begin
            res_nxt.mem_request = 1'b1;
            res_nxt.mem_is_write = 1'b1;
            res_nxt.mem_address = 32'(addr_r);
            res_nxt.mem_write_data = wfifo_r[wtail_r];
            wtail_nxt = bump(wtail_r);
            wcount_nxt = wcount_r - CW'(1);
            adv = 1'b1;
          end
        end else if (run_r && (32'(rcount_r) + 32'(rres_r) < D)) begin
          res_nxt.mem_request = 1'b1;
          res_nxt.mem_address = 32'(addr_r);
          rres_nxt = rres_r + CW'(1);
          adv = 1'b1;
        end
      end
      ssru_pkg::MODE_RSTART, ssru_pkg::MODE_WSTART: begin
        addr_nxt = AW'(q_item.start_address);
        udim_nxt = dim;
        for (int i = 0; i < ND; i++) idx_nxt[i] = '0;
        dirw_nxt = (q_item.mode == ssru_pkg::MODE_WSTART);
        run_nxt  = (q_item.mode == ssru_pkg::MODE_RSTART);
        if (q_item.mode == ssru_pkg::MODE_RSTART) rep_lim_nxt = q_item.repeat_times;
      end
      ssru_pkg::MODE_POP: begin
        if (rcount_r != '0) begin
          res_nxt.pop_value = rfifo_r[rhead_r];
          if (rep_cnt_r >= rep_lim_r) begin
            rep_cnt_nxt = '0;
            rhead_nxt = bump(rhead_r);
            rcount_nxt = rcount_r - CW'(1);
          end else begin
            rep_cnt_nxt = rep_cnt_r + 8'd1;
          end
        end else begin
          res_nxt.status = ssru_pkg::ST_POP_ERR;
        end
      end
      ssru_pkg::MODE_PUSH: begin
        if (32'(wcount_r) < D) begin
          wfifo_we = 1'b1;
          whead_nxt = bump(whead_r);
          wcount_nxt = wcount_r + CW'(1);
        end else begin
          res_nxt.status = ssru_pkg::ST_PUSH_ERR;
        end
      end
      ssru_pkg::MODE_LRET: begin
        if (rres_r != '0 && 32'(rcount_r) < D) begin
          rfifo_we = 1'b1;
          rtail_nxt = bump(rtail_r);
          rcount_nxt = rcount_r + CW'(1);
          rres_nxt = rres_r - CW'(1);
        end
      end
      default: ;
    endcase
    if (adv) begin
      // first non-wrapping dimension (or the top one when all wrap) picks the stride
      for (int i = 0; i < ND; i++) begin
        if (!done && 2'(i) <= udim_r) begin
          addr_nxt = addr_r + AW'($signed(stride_r[i]));
          if (idx_r[i] == bound_r[i]) begin
            idx_nxt[i] = '0;
            if (2'(i) == udim_r) begin
              wrapped = 1'b1;
              done = 1'b1;
            end
          end else begin
            idx_nxt[i] = idx_r[i] + 32'd1;
            done = 1'b1;
          end
        end
      end
      if (wrapped && !dirw_r) run_nxt = 1'b0;
    end
    res_nxt.stream_active = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhead_r <= '0; rtail_r <= '0; whead_r <= '0; wtail_r <= '0;
      rcount_r <= '0; rres_r <= '0; wcount_r <= '0;
      rep_cnt_r <= '0; rep_lim_r <= '0;
      for (int i = 0; i < ND; i++) begin
        idx_r[i] <= '0; bound_r[i] <= '0; stride_r[i] <= '0;
      end
      addr_r <= '0; udim_r <= '0; dirw_r <= 1'b0; run_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx < ssru_pkg::CFG_STRIDE0) bound_r[2'(cfg_idx)] <= cfg_wdata;
        else stride_r[2'(cfg_idx - ssru_pkg::CFG_STRIDE0)] <= cfg_wdata;
      end
      if (go) begin
        rhead_r <= rhead_nxt; rtail_r <= rtail_nxt;
        whead_r <= whead_nxt; wtail_r <= wtail_nxt;
        rcount_r <= rcount_nxt; rres_r <= rres_nxt; wcount_r <= wcount_nxt;
        rep_cnt_r <= rep_cnt_nxt; rep_lim_r <= rep_lim_nxt;
        idx_r <= idx_nxt; addr_r <= addr_nxt; udim_r <= udim_nxt;
        dirw_r <= dirw_nxt; run_r <= run_nxt;
      end
      if (q_ready) out_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_r <= res_nxt;
    if (go && rfifo_we) rfifo_r[rtail_r] <= q_item.payload;
    if (go && wfifo_we) wfifo_r[whead_r] <= q_item.payload;
  end
endmodule

@@ rtl/core/strided_stream_register_unit.sv @@
// channel | direction | handshake
// in_*    | input     | in_valid / in_ready
// out_*   | output    | out_valid / out_ready
// cfg_*   | input     | cfg_we, no wait
// One item per cycle while out_ready stays high; items pass the 2-entry
// queue, then the back end result register. Address step: one 32-bit add.
// Reset (rst_n low, synchronous) clears counters, pointers, config, flags.
// A stalled out_ready holds the result; the queue absorbs two more items.
module strided_stream_register_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_start_address,
  input  logic [1:0]  in_top_dimension,
  input  logic [7:0]  in_repeat_times,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_mem_request,
  output logic        out_mem_is_write,
  output logic [31:0] out_mem_address,
  output logic [63:0] out_mem_write_data,
  output logic [63:0] out_pop_value,
  output logic [1:0]  out_status,
  output logic        out_stream_active
);
  `include "assert_macros.svh"

  ssru_pkg::item_t   in_item, q_item;
  ssru_pkg::result_t res;
  logic q_valid, q_ready, running;

  assign in_item = '{mode: in_mode, start_address: in_start_address,
                     top_dimension: in_top_dimension, repeat_times: in_repeat_times,
                     payload: in_payload};

  ssru_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  ssru_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_wdata(cfg_wdata), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .res_valid(out_valid), .res_ready(out_ready), .res(res), .running(running)
  );

  assign out_mem_request    = res.mem_request;
  assign out_mem_is_write   = res.mem_is_write;
  assign out_mem_address    = res.mem_address;
  assign out_mem_write_data = res.mem_write_data;
  assign out_pop_value      = res.pop_value;
  assign out_status         = res.status;
  assign out_stream_active  = res.stream_active;

  `ASSERT_IMPL(a_err_no_req, clk, rst_n, out_valid && out_status != ssru_pkg::ST_OK,
    !out_mem_request, "error result carries a memory access")
  `ASSERT_IMPL(a_wr_is_req, clk, rst_n, out_valid && out_mem_is_write,
    out_mem_request, "store flag without request")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_mem_address) && $stable(out_pop_value),
    "stalled result changed")
  `ASSERT_IMPL(a_active_match, clk, rst_n, out_valid,
    out_stream_active == running, "stream flag differs from stream state")
endmodule

@@ tb/tb_strided_stream_register_unit.sv @@
`timescale 1ns / 1ps

module tb_strided_stream_register_unit;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int ROUNDS = 12;
  localparam int ITEMS_PER_ROUND = 145;
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [31:0] in_start_address;
  logic [1:0]  in_top_dimension;
  logic [7:0]  in_repeat_times;
  logic [63:0] in_payload;
  logic        out_valid;
  logic        out_ready;
  logic        out_mem_request;
  logic        out_mem_is_write;
  logic [31:0] out_mem_address;
  logic [63:0] out_mem_write_data;
  logic [63:0] out_pop_value;
  logic [1:0]  out_status;
  logic        out_stream_active;

  strided_stream_register_unit i_dut (.*);

  // Shadow state of the unit
  logic [31:0] bound_r [4];
  logic [31:0] stride_r [4];
  logic [63:0] rd_fifo [ssru_pkg::FIFO_DEPTH];
  logic [63:0] wr_fifo [ssru_pkg::FIFO_DEPTH];
  int unsigned rd_head, rd_tail, rd_count, rd_inflight;
  int unsigned wr_head, wr_tail, wr_count;
  int unsigned rep_count, rep_limit;
  logic [31:0] loop_idx [4];
  logic [31:0] cur_addr;
  int unsigned used_dim;
  bit          dir_write;
  bit          rd_running;

  ssru_pkg::item_t   pending_items[$];
  ssru_pkg::result_t expected_results[$];
  int      n_queued, n_accepted, errors;
  int      send_idle_pct, recv_idle_pct;
  bit      in_accepted;
  bit      long_hold_req;
  int      hold_left;
  int      idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned wrap_ptr(int unsigned p);
    return (p + 1 >= ssru_pkg::FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  // Steps the loop nest; returns 1 when the top dimension wraps.
  function automatic bit walk_address(logic [31:0] a);
    for (int i = 0; i <= used_dim; i++) begin
      cur_addr = a + stride_r[i];
      if (loop_idx[i] == bound_r[i]) begin
        loop_idx[i] = 0;
        if (i == used_dim) return 1;
      end else begin
        loop_idx[i] = loop_idx[i] + 1;
        return 0;
      end
    end
    return 0;
  endfunction

  task automatic open_stream(logic [31:0] a, logic [1:0] d);
    cur_addr = a;
    used_dim = d;
    for (int i = 0; i < 4; i++) loop_idx[i] = 0;
  endtask

  task automatic predict_step(ssru_pkg::item_t it);
    ssru_pkg::result_t r;
    r = '0;
    case (it.mode)
      ssru_pkg::MODE_TICK: begin
        if (dir_write) begin
          if (wr_count > 0) begin
            r.mem_request = 1;
            r.mem_is_write = 1;
            r.mem_address = cur_addr;
            r.mem_write_data = wr_fifo[wr_tail];
            wr_tail = wrap_ptr(wr_tail);
            wr_count--;
            void'(walk_address(r.mem_address));
          end
        end else if (rd_running && rd_count + rd_inflight < ssru_pkg::FIFO_DEPTH) begin
          r.mem_request = 1;
          r.mem_address = cur_addr;
          rd_inflight++;
          if (walk_address(r.mem_address)) rd_running = 0;
        end
      end
      ssru_pkg::MODE_RSTART: begin
        open_stream(it.start_address, it.top_dimension);
        dir_write = 0;
        rd_running = 1;
        rep_limit = it.repeat_times;
      end
      ssru_pkg::MODE_WSTART: begin
        open_stream(it.start_address, it.top_dimension);
        dir_write = 1;
        rd_running = 0;
      end
      ssru_pkg::MODE_POP: begin
        if (rd_count > 0) begin
          r.pop_value = rd_fifo[rd_head];
          if (rep_count + 1 > rep_limit) begin
            rep_count = 0;
            rd_head = wrap_ptr(rd_head);
            rd_count--;
          end else begin
            rep_count++;
          end
        end else begin
          r.status = ssru_pkg::ST_POP_ERR;
        end
      end
      ssru_pkg::MODE_PUSH: begin
        if (wr_count < ssru_pkg::FIFO_DEPTH) begin
          wr_fifo[wr_head] = it.payload;
          wr_head = wrap_ptr(wr_head);
          wr_count++;
        end else begin
          r.status = ssru_pkg::ST_PUSH_ERR;
        end
      end
      ssru_pkg::MODE_LRET: begin
        if (rd_inflight > 0 && rd_count < ssru_pkg::FIFO_DEPTH) begin
          rd_fifo[rd_tail] = it.payload;
          rd_tail = wrap_ptr(rd_tail);
          rd_count++;
          rd_inflight--;
        end
      end
      default: ;
    endcase
    r.stream_active = rd_running;
    expected_results.push_back(r);
  endtask

  task automatic add_item(logic [2:0] m, logic [31:0] a, logic [1:0] d, logic [7:0] rep,
                          logic [63:0] p);
    ssru_pkg::item_t it;
    it.mode = m;
    it.start_address = a;
    it.top_dimension = d;
    it.repeat_times = rep;
    it.payload = p;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic add_random_item();
    int unsigned r;
    logic [2:0] m;
    logic [7:0] rep;
    r = $urandom_range(99);
    if (r < 30) m = ssru_pkg::MODE_TICK;
    else if (r < 50) m = ssru_pkg::MODE_LRET;
    else if (r < 72) m = ssru_pkg::MODE_POP;
    else if (r < 83) m = ssru_pkg::MODE_PUSH;
    else if (r < 90) m = ssru_pkg::MODE_RSTART;
    else if (r < 95) m = ssru_pkg::MODE_WSTART;
    else if (r < 98) m = ssru_pkg::MODE_TICK;
    else m = (r == 98) ? MODE_SPARE6 : MODE_SPARE7;
    rep = ($urandom_range(99) < 85) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
    add_item(m, $urandom(), 2'($urandom_range(3)), rep, {$urandom(), $urandom()});
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx < ssru_pkg::CFG_STRIDE0) bound_r[idx[1:0]] = val;
    else stride_r[2'(idx - ssru_pkg::CFG_STRIDE0)] = val;
  endtask

  task automatic load_settings(int round_no);
    logic [31:0] b, s;
    for (int i = 0; i < 4; i++) begin
      case (round_no)
        1: begin b = 0; s = 32'h7FFF_FFFF; end
        2: begin b = 32'hFFFF_FFFF; s = 32'h8000_0000; end
        3: begin b = $urandom_range(3); s = 32'hFFFF_FFFF; end
        default: begin
          b = $urandom_range(3);
          s = $urandom();
        end
      endcase
      write_reg(ssru_pkg::CFG_BOUND0 + 3'(i), b);
      write_reg(ssru_pkg::CFG_STRIDE0 + 3'(i), s);
    end
  endtask

  task automatic drain();
    wait (n_accepted == n_queued && expected_results.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  // Driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ssru_pkg::item_t it;
        it = pending_items.pop_front();
        in_valid <= 1;
        in_mode <= it.mode;
        in_start_address <= it.start_address;
        in_top_dimension <= it.top_dimension;
        in_repeat_times <= it.repeat_times;
        in_payload <= it.payload;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and prediction
  always @(posedge clk) begin
    in_accepted = 0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected");
          errors++;
        end else begin
          ssru_pkg::result_t e;
          e = expected_results.pop_front();
          if (out_mem_request !== e.mem_request) begin
            $error("mem_request exp %0h got %0h", e.mem_request, out_mem_request); errors++;
          end
          if (out_mem_is_write !== e.mem_is_write) begin
            $error("mem_is_write exp %0h got %0h", e.mem_is_write, out_mem_is_write);
            errors++;
          end
          if (out_mem_address !== e.mem_address) begin
            $error("mem_address exp %0h got %0h", e.mem_address, out_mem_address); errors++;
          end
          if (out_mem_write_data !== e.mem_write_data) begin
            $error("mem_write_data exp %0h got %0h", e.mem_write_data, out_mem_write_data);
            errors++;
          end
          if (out_pop_value !== e.pop_value) begin
            $error("pop_value exp %0h got %0h", e.pop_value, out_pop_value); errors++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0h got %0h", e.status, out_status); errors++;
          end
          if (out_stream_active !== e.stream_active) begin
            $error("stream_active exp %0h got %0h", e.stream_active, out_stream_active);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        ssru_pkg::item_t it;
        it.mode = in_mode;
        it.start_address = in_start_address;
        it.top_dimension = in_top_dimension;
        it.repeat_times = in_repeat_times;
        it.payload = in_payload;
        predict_step(it);
        in_accepted = 1;
        n_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_mode = ssru_pkg::MODE_TICK;
    in_start_address = '0;
    in_top_dimension = '0;
    in_repeat_times = '0;
    in_payload = '0;
    out_ready = 0;
    n_queued = 0;
    n_accepted = 0;
    errors = 0;
    send_idle_pct = 7;
    recv_idle_pct = 49;
    long_hold_req = 0;
    hold_left = 0;
    idle_cycles = 0;
    for (int i = 0; i < 4; i++) begin
      bound_r[i] = 0;
      stride_r[i] = 0;
      loop_idx[i] = 0;
    end
    rd_head = 0; rd_tail = 0; rd_count = 0; rd_inflight = 0;
    wr_head = 0; wr_tail = 0; wr_count = 0;
    rep_count = 0; rep_limit = 0;
    cur_addr = 0; used_dim = 0; dir_write = 0; rd_running = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;

    for (int round_no = 0; round_no < ROUNDS; round_no++) begin
      if (round_no == 4) begin send_idle_pct = 49; recv_idle_pct = 7; end
      if (round_no == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      load_settings(round_no);
      if (round_no == 0) begin
        // pop and load return with nothing in flight, spare modes
        add_item(ssru_pkg::MODE_POP, '0, '0, '0, '0);
        add_item(ssru_pkg::MODE_LRET, '0, '0, '0, '1);
        add_item(ssru_pkg::MODE_TICK, '0, '0, '0, '0);
        add_item(MODE_SPARE6, '1, '1, '1, '1);
        add_item(MODE_SPARE7, '1, '1, '1, '1);
        add_item(ssru_pkg::MODE_RSTART, 32'hFFFF_FFFF, 2'd3, 8'd1, '0);
        repeat (5) add_item(ssru_pkg::MODE_TICK, '0, '0, '0, '0);
        add_item(ssru_pkg::MODE_LRET, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(ssru_pkg::MODE_LRET, '0, '0, '0, 64'h0123_4567_89AB_CDEF);
        repeat (5) add_item(ssru_pkg::MODE_POP, '0, '0, '0, '0);
        repeat (5) add_item(ssru_pkg::MODE_PUSH, '0, '0, '0, {$urandom(), $urandom()});
        add_item(ssru_pkg::MODE_WSTART, 32'h0, 2'd0, 8'hFF, '0);
        repeat (3) add_item(ssru_pkg::MODE_TICK, '0, '0, '0, '0);
        add_item(ssru_pkg::MODE_RSTART, 32'h8000_0000, 2'd0, 8'd255, '0);
      end
      if (round_no == 2) long_hold_req = 1;
      for (int k = 0; k < ITEMS_PER_ROUND; k++) add_random_item();
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
